// File: hdl/mhn_pkg.sv
// ----------------------------------------------------------------------------
// mhn_pkg
// shared widths, register indexes and the cordic angle table for the
// magnetometer heading normalizer
// ----------------------------------------------------------------------------
package mhn_pkg;

    localparam int AXIS_W   = 18;   // corrected axis, half-lsb units
    localparam int OFFS_W   = 14;   // offset register width
    localparam int HEAD_W   = 16;   // heading, 1/128 degree
    localparam int UNIT_W   = 16;   // unit vector, q1.15
    localparam int ANG_W    = 25;   // cordic angle accumulator, 1/32768 degree
    localparam int ATAN_LEN = 24;   // cap on cordic iterations; the angle table holds 22 entries

    localparam int HEADING_LIMIT = 23040;
    localparam int UNIT_MAX      = 32767;
    localparam int QUARTER_TURN  = 90 * 32768;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_OFFSET_X = 2'd0,
        REG_OFFSET_Y = 2'd1,
        REG_OFFSET_Z = 2'd2,
        REG_NONE     = 2'd3
    } reg_index_t;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic signed [OFFS_W-1:0] offs_t;
    typedef logic signed [ANG_W-1:0]  ang_t;

    // atan(2^-i) in 1/32768 degree
    function automatic ang_t atan_tab(input int idx);
        ang_t r;
        case (idx)
            0:       r = ANG_W'(1474560);
            1:       r = ANG_W'(870484);
            2:       r = ANG_W'(459940);
            3:       r = ANG_W'(233473);
            4:       r = ANG_W'(117189);
            5:       r = ANG_W'(58652);
            6:       r = ANG_W'(29333);
            7:       r = ANG_W'(14667);
            8:       r = ANG_W'(7334);
            9:       r = ANG_W'(3667);
            10:      r = ANG_W'(1833);
            11:      r = ANG_W'(917);
            12:      r = ANG_W'(458);
            13:      r = ANG_W'(229);
            14:      r = ANG_W'(115);
            15:      r = ANG_W'(57);
            16:      r = ANG_W'(29);
            17:      r = ANG_W'(14);
            18:      r = ANG_W'(7);
            19:      r = ANG_W'(4);
            20:      r = ANG_W'(2);
            21:      r = ANG_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/magnetometer_heading_normalizer_unit.sv
// ----------------------------------------------------------------------------
// magnetometer_heading_normalizer_unit
// hard-iron correction, compass heading and unit vector of a magnetometer word
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one six-byte sensor word (x, z, y, high byte first).
//   m_ channel gives the corrected axes, heading atan2(x,y) in 1/128 degree,
//   the q1.15 unit vector and a zero-vector flag on m_tuser.
//   three offsets are written through cfg_we / cfg_addr / cfg_wdata while
//   the block is idle; index 3 is ignored.
// pipeline stages from an accepted input word to m_tvalid:
//   input correction 1, squares and sum 2, square root 32 (one root bit per
//   stage), divider setup 1, quotient 17 (one bit per stage), output 1.
//   the heading cordic (one rotation per stage) runs beside the root.
// throughput: one word per cycle while the output is not stalled, set by the fully pipelined root and divider.
// reset: all stage valids and m_tvalid clear; offsets return to their
//   defaults (-282, 160, -165).
// stall: the whole pipeline holds while a word waits on m_ and m_tready is
//   low; s_tready follows that enable, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module magnetometer_heading_normalizer_unit #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    // x_high, x_low, z_high, z_low, y_high, y_low
    input  logic [47:0]   s_tdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // corr_x, corr_y, corr_z, heading, unit_x, unit_y, unit_z, 2 pad bits
    output logic [119:0]  m_tdata,
    // zero_field
    output logic          m_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic [mhn_pkg::OFFS_W-1:0] cfg_wdata
);
    import mhn_pkg::*;

    localparam int ITER   = (ANGLE_ITERATIONS > ATAN_LEN) ? ATAN_LEN : ANGLE_ITERATIONS;
    localparam int LAT    = 52;          // last stage of the carry line
    localparam int SQ_N   = 32;          // root bits
    localparam int DV_N   = 17;          // quotient bits
    localparam int HD0    = ITER + 2;    // carry line stage of the rounded heading
    localparam int RM_W   = 36;
    localparam int NUM_W  = 50;
    localparam int CW     = 33;          // cordic datapath

    // configuration registers
    offs_t off_x_reg, off_y_reg, off_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_x_reg <= OFFS_W'(-282);
            off_y_reg <= OFFS_W'(160);
            off_z_reg <= OFFS_W'(-165);
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_addr))
                REG_OFFSET_X: off_x_reg <= cfg_wdata;
                REG_OFFSET_Y: off_y_reg <= cfg_wdata;
                REG_OFFSET_Z: off_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // global advance: move when the output slot is free or being taken
    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // carry line: valid and corrected axes ride along every stage
    logic  vld_reg [0:LAT];
    axis_t x_reg   [0:LAT];
    axis_t y_reg   [0:LAT];
    axis_t z_reg   [0:LAT];

    // stage 0: join bytes, double, subtract offset
    axis_t x_next, y_next, z_next;
    always_comb begin
        x_next = AXIS_W'($signed({s_tdata[7:0],   s_tdata[15:8],  1'b0}))
               - AXIS_W'(off_x_reg);
        z_next = AXIS_W'($signed({s_tdata[23:16], s_tdata[31:24], 1'b0}))
               - AXIS_W'(off_z_reg);
        y_next = AXIS_W'($signed({s_tdata[39:32], s_tdata[47:40], 1'b0}))
               - AXIS_W'(off_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAT; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k <= LAT; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= x_next;
            y_reg[0] <= y_next;
            z_reg[0] <= z_next;
            for (int k = 1; k <= LAT; k++) begin
                x_reg[k] <= x_reg[k-1];
                y_reg[k] <= y_reg[k-1];
                z_reg[k] <= z_reg[k-1];
            end
        end
    end

    // squares, then their sum (stage 1 and 2)
    logic [32:0] sqx_reg, sqy_reg, sqz_reg;
    logic [35:0] sq_s_reg  [0:SQ_N-1];
    logic [31:0] sq_rt_reg [0:SQ_N];
    logic [RM_W-1:0] sq_rm_reg [0:SQ_N];

    logic signed [35:0] px, py, pz;
    assign px = x_reg[0] * x_reg[0];
    assign py = y_reg[0] * y_reg[0];
    assign pz = z_reg[0] * z_reg[0];

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg      <= px[32:0];
            sqy_reg      <= py[32:0];
            sqz_reg      <= pz[32:0];
            sq_s_reg[0]  <= 36'(sqx_reg) + 36'(sqy_reg) + 36'(sqz_reg);
            sq_rt_reg[0] <= '0;
            sq_rm_reg[0] <= '0;
        end
    end

    // square root of s * 2^28, one root bit per stage
    genvar gj;
    generate
        for (gj = 1; gj <= SQ_N; gj++) begin : g_sqrt
            localparam int K = SQ_N - gj;
            logic [1:0]      pair;
            logic [RM_W-1:0] rm_sh, trial;
            logic            take;
            if (2 * K >= 28) begin : g_bits
                assign pair = sq_s_reg[gj-1][2*K-27:2*K-28];
            end else begin : g_zero
                assign pair = 2'b00;
            end
            assign rm_sh = {sq_rm_reg[gj-1][RM_W-3:0], pair};
            assign trial = RM_W'({sq_rt_reg[gj-1], 2'b01});
            assign take  = rm_sh >= trial;
            always_ff @(posedge aclk) begin
                if (en) begin
                    sq_rm_reg[gj] <= take ? rm_sh - trial : rm_sh;
                    sq_rt_reg[gj] <= {sq_rt_reg[gj-1][30:0], take};
                end
            end
            if (gj < SQ_N) begin : g_pass
                always_ff @(posedge aclk) begin
                    if (en) sq_s_reg[gj] <= sq_s_reg[gj-1];
                end
            end
        end
    endgenerate

    // divider setup: n = |v| * 2^30 + m, d = 2m (carry line stage 35)
    logic [NUM_W-1:0] dv_rm_reg [0:DV_N][0:2];
    logic [16:0]      dv_q_reg  [0:DV_N][0:2];
    logic [32:0]      dv_d_reg  [0:DV_N];

    function automatic logic [16:0] mag_of(input axis_t v);
        axis_t a;
        a = v[AXIS_W-1] ? -v : v;
        return a[16:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_d_reg[0]     <= {sq_rt_reg[SQ_N], 1'b0};
            dv_rm_reg[0][0] <= NUM_W'({mag_of(x_reg[34]), 30'b0}) + NUM_W'(sq_rt_reg[SQ_N]);
            dv_rm_reg[0][1] <= NUM_W'({mag_of(y_reg[34]), 30'b0}) + NUM_W'(sq_rt_reg[SQ_N]);
            dv_rm_reg[0][2] <= NUM_W'({mag_of(z_reg[34]), 30'b0}) + NUM_W'(sq_rt_reg[SQ_N]);
            for (int v = 0; v < 3; v++) dv_q_reg[0][v] <= '0;
        end
    end

    // restoring division, one quotient bit per stage
    genvar gi, gv;
    generate
        for (gi = 1; gi <= DV_N; gi++) begin : g_div
            localparam int B = DV_N - gi;
            logic [NUM_W-1:0] dsh;
            assign dsh = NUM_W'(dv_d_reg[gi-1]) << B;
            always_ff @(posedge aclk) begin
                if (en) dv_d_reg[gi] <= dv_d_reg[gi-1];
            end
            for (gv = 0; gv < 3; gv++) begin : g_lane
                logic take;
                assign take = dv_rm_reg[gi-1][gv] >= dsh;
                always_ff @(posedge aclk) begin
                    if (en) begin
                        dv_rm_reg[gi][gv] <= take ? dv_rm_reg[gi-1][gv] - dsh
                                                  : dv_rm_reg[gi-1][gv];
                        dv_q_reg[gi][gv]  <= {dv_q_reg[gi-1][gv][15:0], take};
                    end
                end
            end
        end
    endgenerate

    // heading cordic, vectoring mode on (a = y, b = x)
    logic signed [CW-1:0] ca_reg [0:ITER];
    logic signed [CW-1:0] cb_reg [0:ITER];
    ang_t                 cacc_reg [0:ITER];
    logic signed [HEAD_W-1:0] hd_reg [HD0:LAT];

    logic signed [CW-1:0] a0, b0;
    assign a0 = CW'($signed({y_reg[0], 12'b0}));
    assign b0 = CW'($signed({x_reg[0], 12'b0}));

    always_ff @(posedge aclk) begin
        if (en) begin
            if (a0 < 0 && b0 >= 0) begin
                ca_reg[0]   <= b0;
                cb_reg[0]   <= -a0;
                cacc_reg[0] <= ANG_W'(QUARTER_TURN);
            end else if (a0 < 0) begin
                ca_reg[0]   <= -b0;
                cb_reg[0]   <= a0;
                cacc_reg[0] <= ANG_W'(-QUARTER_TURN);
            end else begin
                ca_reg[0]   <= a0;
                cb_reg[0]   <= b0;
                cacc_reg[0] <= '0;
            end
        end
    end

    generate
        for (gi = 1; gi <= ITER; gi++) begin : g_cordic
            logic signed [CW-1:0] sa, sb;
            assign sa = ca_reg[gi-1] >>> (gi - 1);
            assign sb = cb_reg[gi-1] >>> (gi - 1);
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (cb_reg[gi-1] > 0) begin
                        ca_reg[gi]   <= ca_reg[gi-1] + sb;
                        cb_reg[gi]   <= cb_reg[gi-1] - sa;
                        cacc_reg[gi] <= cacc_reg[gi-1] + atan_tab(gi - 1);
                    end else begin
                        ca_reg[gi]   <= ca_reg[gi-1] - sb;
                        cb_reg[gi]   <= cb_reg[gi-1] + sa;
                        cacc_reg[gi] <= cacc_reg[gi-1] - atan_tab(gi - 1);
                    end
                end
            end
        end
    endgenerate

    // round to 1/128 degree and clamp, then delay to the output
    ang_t acc_rnd;
    logic signed [16:0] h_full;
    logic signed [HEAD_W-1:0] h_clamp;
    always_comb begin
        acc_rnd = cacc_reg[ITER] + ANG_W'(128);
        h_full  = 17'(acc_rnd >>> 8);
        if (h_full > 17'sd23040)       h_clamp = HEAD_W'(HEADING_LIMIT);
        else if (h_full < -17'sd23040) h_clamp = HEAD_W'(-HEADING_LIMIT);
        else                           h_clamp = h_full[HEAD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hd_reg[HD0] <= h_clamp;
            for (int k = HD0 + 1; k <= LAT; k++) hd_reg[k] <= hd_reg[k-1];
        end
    end

    // output register
    logic signed [UNIT_W-1:0] u_next [0:2];
    logic signed [HEAD_W-1:0] hd_next;
    logic                     zero_next;
    logic [2:0]               neg;
    assign neg = {z_reg[LAT][AXIS_W-1], y_reg[LAT][AXIS_W-1], x_reg[LAT][AXIS_W-1]};
    assign zero_next = (x_reg[LAT] == '0) && (y_reg[LAT] == '0) && (z_reg[LAT] == '0);

    always_comb begin
        logic [UNIT_W-1:0] mg;
        for (int v = 0; v < 3; v++) begin
            mg = (dv_q_reg[DV_N][v] > 17'(UNIT_MAX)) ? UNIT_W'(UNIT_MAX)
                                                    : dv_q_reg[DV_N][v][UNIT_W-1:0];
            if (zero_next)   u_next[v] = '0;
            else if (neg[v]) u_next[v] = -$signed(mg);
            else             u_next[v] = $signed(mg);
        end
        hd_next = (x_reg[LAT] == '0 && y_reg[LAT] == '0) ? '0 : hd_reg[LAT];
    end

    logic [119:0] m_data_reg;
    logic         m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[LAT];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {2'b00, u_next[2], u_next[1], u_next[0], hd_next,
                           z_reg[LAT], y_reg[LAT], x_reg[LAT]};
            m_user_reg <= zero_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
